FILE: rtl/core/kwsc_pkg.sv
`timescale 1ns / 1ps
// kwsc_pkg: shared types, constants and helpers for the keyword cipher unit
// no dependencies; imported by the controller, datapath and top level

package kwsc_pkg;

  localparam int LETTER_COUNT = 26;
  localparam int IDX_W        = $clog2(LETTER_COUNT);
  localparam int CHAR_W       = 8;
  localparam int MODE_W       = 2;

  localparam logic [CHAR_W-1:0] CODE_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CODE_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CODE_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CODE_LOWER_Z = 8'h7A;

  typedef enum logic [MODE_W-1:0] {
    MODE_KEY = 2'd0,
    MODE_END = 2'd1,
    MODE_ENC = 2'd2,
    MODE_DEC = 2'd3
  } mode_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WALK = 1'b1
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic kw_char;
    logic walk_start;
    logic walk_step;
    logic walk_finish;
    logic text_load;
  } kwsc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic complete;
    logic walk_last;
  } kwsc_status_t;

  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] idx;
  } letter_t;

  // letter index of a character code, either case; ok low for non-letters
  function automatic letter_t letter_index(input logic [CHAR_W-1:0] c);
    letter_t r;
    logic [CHAR_W-1:0] diff;
    r.ok  = 1'b0;
    r.idx = '0;
    diff  = '0;
    if (c >= CODE_UPPER_A && c <= CODE_UPPER_Z) begin
      diff  = c - CODE_UPPER_A;
      r.ok  = 1'b1;
      r.idx = diff[IDX_W-1:0];
    end else if (c >= CODE_LOWER_A && c <= CODE_LOWER_Z) begin
      diff  = c - CODE_LOWER_A;
      r.ok  = 1'b1;
      r.idx = diff[IDX_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/kwsc_if.sv
`timescale 1ns / 1ps
// kwsc_if: valid/ready channel interfaces for request items and result items
// depends on kwsc_pkg for field widths

interface kwsc_req_if;
  import kwsc_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [CHAR_W-1:0] char_in;

  modport source (output valid, output mode, output char_in, input ready);
  modport sink   (input valid, input mode, input char_in, output ready);
endinterface

interface kwsc_rsp_if;
  import kwsc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_out;
  logic              not_ready;

  modport source (output valid, output char_out, output not_ready, input ready);
  modport sink   (input valid, input char_out, input not_ready, output ready);
endinterface

FILE: rtl/core/kwsc_ctrl.sv
`timescale 1ns / 1ps
// kwsc_ctrl: control state machine for the keyword cipher unit
// depends on kwsc_pkg; drives commands to kwsc_datapath and owns the handshakes

module kwsc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  kwsc_pkg::mode_t       req_mode,
  output logic                  req_ready,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  input  kwsc_pkg::kwsc_status_t status,
  output kwsc_pkg::kwsc_cmd_t   cmd
);
  import kwsc_pkg::*;

  state_t state;
  state_t state_next;
  logic   pend_valid;
  logic   pend_valid_next;
  logic   accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_comb begin
    state_next      = state;
    cmd             = '0;
    req_ready       = 1'b0;
    accept          = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready = !pend_valid || rsp_ready;
        accept    = req_valid && req_ready;
        if (accept) begin
          case (req_mode)
            MODE_KEY: cmd.kw_char = 1'b1;
            MODE_END: begin
              // a second keyword end leaves the tables alone
              if (!status.complete) begin
                cmd.walk_start = 1'b1;
                state_next     = ST_WALK;
              end
            end
            MODE_ENC, MODE_DEC: cmd.text_load = 1'b1;
            default: cmd = '0;
          endcase
        end
      end
      ST_WALK: begin
        cmd.walk_step = 1'b1;
        if (status.walk_last) begin
          cmd.walk_finish = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    if (cmd.text_load) begin
      pend_valid_next = 1'b1;
    end else if (rsp_ready) begin
      pend_valid_next = 1'b0;
    end else begin
      pend_valid_next = pend_valid;
    end
  end

  assign rsp_valid = pend_valid;

  a_text_gives_result: assert property (@(posedge clk) disable iff (rst)
    cmd.text_load |=> rsp_valid)
    else $error("text item accepted but no result pending");

  a_walk_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cmd.walk_start |=> (state == ST_WALK) && !req_ready)
    else $error("input taken during alphabet fill walk");

  a_finish_on_last: assert property (@(posedge clk) disable iff (rst)
    cmd.walk_finish |-> cmd.walk_step && status.walk_last)
    else $error("fill walk ended off its last letter");

endmodule

FILE: rtl/core/kwsc_datapath.sv
`timescale 1ns / 1ps
// kwsc_datapath: cipher tables, alphabet fill state and result registers
// depends on kwsc_pkg; commanded by kwsc_ctrl

module kwsc_datapath (
  input  logic                    clk,
  input  logic                    rst,
  input  kwsc_pkg::kwsc_cmd_t     cmd,
  output kwsc_pkg::kwsc_status_t  status,
  input  logic                    req_mode_dec,
  input  logic [kwsc_pkg::CHAR_W-1:0] char_in,
  output logic [kwsc_pkg::CHAR_W-1:0] char_out,
  output logic                    not_ready
);
  import kwsc_pkg::*;

  // forward and inverse tables; written together as each letter is appended
  logic [IDX_W-1:0] fwd_mem [LETTER_COUNT];
  logic [IDX_W-1:0] inv_mem [LETTER_COUNT];

  logic [LETTER_COUNT-1:0] used;
  logic [IDX_W-1:0]        fill;
  logic                    complete;
  logic [IDX_W-1:0]        walk_k;

  // pending result
  logic [IDX_W-1:0]  rd_fwd;
  logic [IDX_W-1:0]  rd_inv;
  logic [CHAR_W-1:0] pend_char;
  logic              pend_letter;
  logic              pend_dec;
  logic              pend_not_ready;

  letter_t                 in_letter;
  logic [LETTER_COUNT-1:0] used_eff;
  logic [IDX_W-1:0]        fill_eff;
  logic [IDX_W-1:0]        app_idx;
  logic                    app_en;
  logic                    app_do;
  logic [LETTER_COUNT-1:0] used_next;
  logic [IDX_W-1:0]        fill_next;
  logic [IDX_W-1:0]        sel_idx;

  always_comb begin
    in_letter = letter_index(char_in);
    // a keyword character after completion starts over
    if (cmd.kw_char && complete) begin
      used_eff = '0;
      fill_eff = '0;
    end else begin
      used_eff = used;
      fill_eff = fill;
    end
    app_idx = cmd.walk_step ? walk_k : in_letter.idx;
    app_en  = (cmd.kw_char && in_letter.ok) || cmd.walk_step;
    app_do  = app_en && (fill_eff < IDX_W'(LETTER_COUNT)) && !used_eff[app_idx];
    used_next = used_eff;
    fill_next = fill_eff;
    if (app_do) begin
      used_next[app_idx] = 1'b1;
      fill_next          = fill_eff + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used     <= '0;
      fill     <= '0;
      complete <= 1'b0;
      walk_k   <= '0;
    end else begin
      used <= used_next;
      fill <= fill_next;
      if (cmd.kw_char) begin
        complete <= 1'b0;
      end else if (cmd.walk_finish) begin
        complete <= 1'b1;
      end
      if (cmd.walk_start) begin
        walk_k <= '0;
      end else if (cmd.walk_step) begin
        walk_k <= walk_k + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (app_do) begin
      fwd_mem[fill_eff] <= app_idx;
      inv_mem[app_idx]  <= fill_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.text_load) begin
      rd_fwd         <= fwd_mem[in_letter.idx];
      rd_inv         <= inv_mem[in_letter.idx];
      pend_char      <= char_in;
      pend_letter    <= in_letter.ok;
      pend_dec       <= req_mode_dec;
      pend_not_ready <= !complete;
    end
  end

  always_comb begin
    sel_idx = pend_dec ? rd_inv : rd_fwd;
    if (!pend_not_ready && pend_letter) begin
      char_out = CODE_UPPER_A + CHAR_W'(sel_idx);
    end else begin
      char_out = pend_char;
    end
  end

  assign not_ready        = pend_not_ready;
  assign status.complete  = complete;
  assign status.walk_last = (walk_k == IDX_W'(LETTER_COUNT - 1));

  a_count_matches_used: assert property (@(posedge clk) disable iff (rst)
    $countones(used) == int'(fill))
    else $error("fill count out of step with used letters");

  a_complete_is_full: assert property (@(posedge clk) disable iff (rst)
    complete |-> (fill == IDX_W'(LETTER_COUNT)) && (&used))
    else $error("alphabet marked complete while not full");

  a_finish_sets_complete: assert property (@(posedge clk) disable iff (rst)
    cmd.walk_finish |=> complete)
    else $error("fill walk ended without completing the alphabet");

endmodule

FILE: rtl/core/keyword_substitution_cipher_unit.sv
`timescale 1ns / 1ps
// keyword_substitution_cipher_unit: top level of the keyword cipher
// depends on kwsc_pkg, kwsc_if, kwsc_ctrl and kwsc_datapath
//
// usage:
//   request carries one item per handshake: mode and char_in. mode keyword
//   character appends an unused letter to the cipher alphabet, keyword end
//   fills in the remaining letters A to Z, encrypt and decrypt map a letter
//   through the tables and pass other characters unchanged.
//   result carries char_out and not_ready, one item per encrypt or decrypt
//   item; keyword items give no result. not_ready is set for text sent
//   before the alphabet is complete.
//   a result is valid in the cycle after its item is accepted.
//   keyword and text items can be taken back to back; a keyword end item
//   on an incomplete alphabet walks the 26 letters, one per cycle, and no
//   item is taken until the walk is done. a stalled result holds; a new
//   item is taken in the cycle the held result is taken, so outside a walk
//   items stream at one per cycle while result.ready is high.
//   reset (rst, synchronous) empties the alphabet and drops any held result;
//   the tables themselves are rewritten by the next keyword.

module keyword_substitution_cipher_unit (
  input  logic            clk,
  input  logic            rst,
  kwsc_req_if.sink        request,
  kwsc_rsp_if.source      result
);
  import kwsc_pkg::*;

  kwsc_cmd_t    cmd;
  kwsc_status_t status;
  mode_t        req_mode;

  assign req_mode = mode_t'(request.mode);

  kwsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_mode  (req_mode),
    .req_ready (request.ready),
    .rsp_valid (result.valid),
    .rsp_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  kwsc_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .req_mode_dec (req_mode == MODE_DEC),
    .char_in      (request.char_in),
    .char_out     (result.char_out),
    .not_ready    (result.not_ready)
  );

endmodule

FILE: tb/sv/keyword_substitution_cipher_unit_tb.sv
`timescale 1ns / 1ps
// keyword_substitution_cipher_unit_tb: self-checking bench for the keyword cipher unit
// predicts every result from its own cipher tables; depends on kwsc_pkg, kwsc_if and the rtl

module keyword_substitution_cipher_unit_tb;
  import kwsc_pkg::*;

  typedef struct {
    logic [CHAR_W-1:0] char_out;
    logic              not_ready;
  } cipher_out_t;

  logic clk;
  logic rst;

  kwsc_req_if request ();
  kwsc_rsp_if result ();

  keyword_substitution_cipher_unit dut (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .result  (result)
  );

  // expected results, oldest first
  cipher_out_t pending_out[$];

  // predicted cipher state
  logic [IDX_W-1:0]        plain_to_cipher [LETTER_COUNT];
  logic [IDX_W-1:0]        cipher_to_plain [LETTER_COUNT];
  logic [LETTER_COUNT-1:0] letters_taken = '0;
  int                      alphabet_len  = 0;
  bit                      alphabet_done = 1'b0;

  int errors         = 0;
  int sent_count     = 0;
  int tx_idle_pct    = 0;
  int rx_stall_pct   = 0;
  int rx_hold_cycles = 0;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic bit is_letter(input logic [CHAR_W-1:0] c, output logic [IDX_W-1:0] pos);
    logic [CHAR_W-1:0] off;
    pos = '0;
    if (c >= CODE_UPPER_A && c <= CODE_UPPER_Z) begin
      off = c - CODE_UPPER_A;
    end else if (c >= CODE_LOWER_A && c <= CODE_LOWER_Z) begin
      off = c - CODE_LOWER_A;
    end else begin
      return 1'b0;
    end
    pos = off[IDX_W-1:0];
    return 1'b1;
  endfunction

  function automatic void add_letter(input logic [IDX_W-1:0] pos);
    if (alphabet_len < LETTER_COUNT && !letters_taken[pos]) begin
      plain_to_cipher[alphabet_len] = pos;
      alphabet_len++;
      letters_taken[pos] = 1'b1;
    end
  endfunction

  function automatic void cipher_predict(input mode_t op, input logic [CHAR_W-1:0] ch);
    logic [IDX_W-1:0] pos;
    bit               letter;
    cipher_out_t      want;
    letter = is_letter(ch, pos);
    case (op)
      MODE_KEY: begin
        // a keyword character after completion starts over
        if (alphabet_done) begin
          letters_taken = '0;
          alphabet_len  = 0;
          alphabet_done = 1'b0;
        end
        if (letter) add_letter(pos);
      end
      MODE_END: begin
        if (!alphabet_done) begin
          for (int k = 0; k < LETTER_COUNT; k++) add_letter(k[IDX_W-1:0]);
          for (int k = 0; k < LETTER_COUNT; k++)
            cipher_to_plain[plain_to_cipher[k]] = k[IDX_W-1:0];
          alphabet_done = 1'b1;
        end
      end
      default: begin
        want.not_ready = !alphabet_done;
        if (!alphabet_done || !letter) begin
          want.char_out = ch;
        end else if (op == MODE_ENC) begin
          want.char_out = CODE_UPPER_A + plain_to_cipher[pos];
        end else begin
          want.char_out = CODE_UPPER_A + cipher_to_plain[pos];
        end
        pending_out.push_back(want);
      end
    endcase
  endfunction

  // result check first, then the item taken at this edge
  always @(posedge clk) begin : check_result
    cipher_out_t want;
    if (!rst) begin
      if (result.valid && result.ready) begin
        if (pending_out.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got char_out %h not_ready %b",
                   $time, result.char_out, result.not_ready);
        end else begin
          want = pending_out.pop_front();
          if (result.char_out !== want.char_out) begin
            errors++;
            $display("%0t: char_out mismatch, expected %h, got %h",
                     $time, want.char_out, result.char_out);
          end
          if (result.not_ready !== want.not_ready) begin
            errors++;
            $display("%0t: not_ready mismatch, expected %b, got %b",
                     $time, want.not_ready, result.not_ready);
          end
        end
      end
      if (request.valid && request.ready) cipher_predict(mode_t'(request.mode), request.char_in);
    end
  end

  // result side: random stalls, or a counted hold-off
  initial begin
    result.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        result.ready <= 1'b0;
        rx_hold_cycles--;
      end else begin
        result.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // called at a falling edge; leaves valid high so the next item can follow at once
  task automatic send_item(input mode_t op, input logic [CHAR_W-1:0] ch);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      request.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    request.valid   <= 1'b1;
    request.mode    <= op;
    request.char_in <= ch;
    do @(posedge clk); while (!request.ready);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    request.valid <= 1'b0;
    do @(negedge clk); while (pending_out.size() != 0);
  endtask

  function automatic logic [CHAR_W-1:0] random_letter();
    logic [CHAR_W-1:0] base;
    base = $urandom_range(1) ? CODE_LOWER_A : CODE_UPPER_A;
    return base + CHAR_W'($urandom_range(LETTER_COUNT - 1));
  endfunction

  function automatic logic [CHAR_W-1:0] random_char();
    return CHAR_W'($urandom_range(255));
  endfunction

  function automatic logic [CHAR_W-1:0] random_text_char();
    if ($urandom_range(9) < 7) return random_letter();
    return random_char();
  endfunction

  function automatic mode_t random_text_mode();
    if ($urandom_range(1)) return MODE_DEC;
    return MODE_ENC;
  endfunction

  // keyword, keyword end, then text; some noise along the way
  task automatic cipher_session(input int text_len);
    int                order[LETTER_COUNT];
    int                shape;
    int                key_len;
    int                j;
    int                tmp;
    logic [CHAR_W-1:0] base;
    shape = $urandom_range(9);
    if (shape == 0) begin
      // every letter in the keyword, so the fill walk adds nothing
      for (int i = 0; i < LETTER_COUNT; i++) order[i] = i;
      for (int i = LETTER_COUNT - 1; i > 0; i--) begin
        j        = $urandom_range(i);
        tmp      = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
      for (int i = 0; i < LETTER_COUNT; i++) begin
        base = $urandom_range(1) ? CODE_LOWER_A : CODE_UPPER_A;
        send_item(MODE_KEY, base + CHAR_W'(order[i]));
      end
    end else begin
      key_len = (shape == 1) ? $urandom_range(40) : $urandom_range(10);
      for (int i = 0; i < key_len; i++) begin
        if ($urandom_range(9) == 0) send_item(random_text_mode(), random_text_char());
        if ($urandom_range(6) == 0) send_item(MODE_KEY, random_char());
        else send_item(MODE_KEY, random_letter());
      end
    end
    send_item(MODE_END, random_char());
    if ($urandom_range(9) == 0) send_item(MODE_END, random_char());
    for (int i = 0; i < text_len; i++) send_item(random_text_mode(), random_text_char());
  endtask

  task automatic test_text_before_key();
    send_item(MODE_ENC, CODE_UPPER_A);
    send_item(MODE_DEC, CODE_LOWER_Z);
    send_item(MODE_ENC, 8'h00);
    send_item(MODE_DEC, 8'hFF);
  endtask

  task automatic test_keyword_build();
    send_item(MODE_KEY, "k");
    send_item(MODE_KEY, "E");
    send_item(MODE_KEY, "y");
    send_item(MODE_KEY, "K");   // repeat in the other case
    send_item(MODE_KEY, "1");   // not a letter
    send_item(MODE_KEY, 8'hC1); // high bit set, not a letter
    send_item(MODE_END, 8'h00);
  endtask

  task automatic test_text_mapping();
    send_item(MODE_ENC, CODE_UPPER_A);
    send_item(MODE_ENC, CODE_UPPER_Z);
    send_item(MODE_ENC, CODE_LOWER_A);
    send_item(MODE_ENC, CODE_LOWER_Z);
    send_item(MODE_ENC, CODE_UPPER_A - CHAR_W'(1));
    send_item(MODE_DEC, CODE_UPPER_Z + CHAR_W'(1));
    send_item(MODE_DEC, CODE_LOWER_A - CHAR_W'(1));
    send_item(MODE_DEC, CODE_LOWER_Z + CHAR_W'(1));
    send_item(MODE_DEC, "K");
    send_item(MODE_DEC, "a");
  endtask

  task automatic test_end_repeat_and_restart();
    send_item(MODE_END, 8'hFF); // ignored, tables kept
    send_item(MODE_ENC, "b");
    send_item(MODE_KEY, "#");   // restarts even though not a letter
    send_item(MODE_ENC, "q");
    send_item(MODE_END, 8'h00); // empty keyword gives the plain alphabet
    send_item(MODE_DEC, "Q");
  endtask

  task automatic test_result_backpressure();
    rx_hold_cycles = 60;
    repeat (12) send_item(random_text_mode(), random_text_char());
  endtask

  task automatic test_drain_pause();
    repeat (5) send_item(random_text_mode(), random_text_char());
    wait_drained();
    repeat (5) send_item(random_text_mode(), random_text_char());
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int items);
    int start;
    wait_drained();
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    start        = sent_count;
    while (sent_count - start < items) cipher_session($urandom_range(4, 30));
  endtask

  initial begin
    rst             = 1'b1;
    request.valid   = 1'b0;
    request.mode    = MODE_KEY;
    request.char_in = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_text_before_key();
    test_keyword_build();
    test_text_mapping();
    test_end_repeat_and_restart();
    test_result_backpressure();
    test_drain_pause();
    test_random_traffic(0, 0, 100);
    test_random_traffic(80, 0, 100);
    test_random_traffic(0, 80, 100);
    test_random_traffic(13, 13, 100);

    wait_drained();
    repeat (30) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
